@@ hdl/bpa_pkg.sv @@
// Shared types and constants for the bitmap page allocator.
// Used by bpa_word_scan and bitmap_page_allocator; depends on nothing else.
package bpa_pkg;

    localparam int PAGES     = 4096;
    localparam int WORD_BITS = 64;
    localparam int WORDS     = PAGES / WORD_BITS;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESERVE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NORUN = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] first_page;
        logic [12:0] page_count;
        logic        count_as_used;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] start_page;
        logic [12:0] used_pages;
    } t_resp;

    // Result of searching one bitmap word for the end of a free run.
    typedef struct packed {
        logic        found;
        logic [11:0] start;
        logic [12:0] run;
    } t_scan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

@@ hdl/bpa_word_scan.sv @@
// First-fit search over one 64-bit bitmap word, given the free run carried in.
// Depends on bpa_pkg for widths and the t_scan result type.
module bpa_word_scan (
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [bpa_pkg::WADDR_W-1:0]   i_word_idx,
    input  logic [12:0]                   i_run,
    input  logic [12:0]                   i_count,
    output bpa_pkg::t_scan                o_res
);
    import bpa_pkg::*;

    function automatic logic [BIT_W:0] lowest_one(logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] res;
        res = (BIT_W + 1)'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) res = (BIT_W + 1)'(i);
        end
        return res;
    endfunction

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] pw;
    logic [WORD_BITS-1:0] acc;
    logic [BIT_W:0]       trail;
    logic [BIT_W:0]       lead;
    logic [BIT_W:0]       hit_pos;
    logic [13:0]          prefix_sum;
    logic                 prefix_hit;
    logic                 inner_hit;
    logic [12:0]          base;
    logic [12:0]          inner_start;

    always_comb begin
        free_bits = ~i_word;
        // acc marks each bit where i_count consecutive free pages, wholly
        // inside this word, end. Built from power-of-two run masks.
        pw  = free_bits;
        acc = '1;
        for (int b = 0; b <= BIT_W; b++) begin
            if (i_count[b]) acc = pw & (acc << (1 << b));
            pw = pw & (pw << (1 << b));
        end
        inner_hit = (i_count <= 13'(WORD_BITS)) && (|acc);
        hit_pos   = lowest_one(acc);

        trail = lowest_one(i_word);
        lead  = (BIT_W + 1)'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i_word[i]) lead = (BIT_W + 1)'(WORD_BITS - 1 - i);
        end

        prefix_sum = {1'b0, i_run} + 14'(trail);
        prefix_hit = prefix_sum >= {1'b0, i_count};

        base        = 13'({i_word_idx, {BIT_W{1'b0}}});
        inner_start = base + 13'(hit_pos) + 13'd1 - i_count;

        // A run carried in from lower words always ends before any run that
        // lies wholly inside this word, so it takes priority.
        o_res.found = prefix_hit || inner_hit;
        if (prefix_hit) begin
            o_res.start = base[11:0] - i_run[11:0];
        end else begin
            o_res.start = inner_start[11:0];
        end
        if (i_word == '0) begin
            o_res.run = i_run + 13'(WORD_BITS);
        end else begin
            o_res.run = 13'(lead);
        end
    end

endmodule

@@ hdl/bitmap_page_allocator.sv @@
// Bitmap first-fit page allocator: 64 x 64-bit bitmap memory and a used-page count.
// Allocate scans from word 0 for the first free run, then writes each word of that run.
// Free or reserve writes each word of the given run; a bad request goes to the output state.
// One request is in work at a time; the memory's single read port reads one word a
// cycle. Reset is synchronous: per-word valid flags clear at once, so the bitmap reads
// as all free without a clearing pass.
module bitmap_page_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  bpa_pkg::t_req  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output bpa_pkg::t_resp o_out_data,
    input  logic           i_out_stall
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_q;
    logic                 r_q_valid;
    logic [WORDS-1:0]     r_valid;

    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] q_word;

    t_state             r_state, n_state;
    logic [WADDR_W-1:0] r_word, n_word;
    logic [12:0]        r_run, n_run;
    logic [1:0]         r_mode, n_mode;
    logic [12:0]        r_count, n_count;
    logic               r_as_used, n_as_used;
    logic [11:0]        r_first, n_first;
    logic [11:0]        r_last, n_last;
    logic [1:0]         r_status, n_status;
    logic [11:0]        r_start, n_start;
    logic [12:0]        r_used, n_used;
    logic               r_out_valid, n_out_valid;
    t_resp              r_out, n_out;

    t_scan                scan;
    logic [13:0]          idx_end;
    logic [12:0]          last_calc;
    logic [13:0]          add_sum;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] mask;
    logic                 type_ok;

    // The read of word w+1 overlaps the write of word w, and a request starts
    // reading only after the previous one has finished writing, so the same
    // entry is never read and written in one cycle while its data matters.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_word] <= wr_data;
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (wr_en) r_valid[r_word] <= 1'b1;
            r_q_valid <= r_valid[rd_addr];
        end
    end

    assign q_word = r_q_valid ? r_q : '0;

    bpa_word_scan u_scan (
        .i_word     (q_word),
        .i_word_idx (r_word),
        .i_run      (r_run),
        .i_count    (r_count),
        .o_res      (scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_run     <= n_run;
        r_mode    <= n_mode;
        r_count   <= n_count;
        r_as_used <= n_as_used;
        r_first   <= n_first;
        r_last    <= n_last;
        r_status  <= n_status;
        r_start   <= n_start;
        r_out     <= n_out;
    end

    always_comb begin
        idx_end   = {2'b00, i_in_data.first_page} + {1'b0, i_in_data.page_count};
        type_ok   = (i_in_data.req_type == REQ_ALLOC) || (i_in_data.req_type == REQ_FREE)
                 || (i_in_data.req_type == REQ_RESERVE);
        last_calc = 13'(scan.start) + r_count - 13'd1;
        add_sum   = {1'b0, r_used} + {1'b0, r_count};

        lo_bit = (r_word == r_first[11:BIT_W]) ? r_first[BIT_W-1:0] : '0;
        hi_bit = (r_word == r_last[11:BIT_W])  ? r_last[BIT_W-1:0]  : '1;
        mask   = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));

        n_state     = r_state;
        n_word      = r_word;
        n_run       = r_run;
        n_mode      = r_mode;
        n_count     = r_count;
        n_as_used   = r_as_used;
        n_first     = r_first;
        n_last      = r_last;
        n_status    = r_status;
        n_start     = r_start;
        n_used      = r_used;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_data     = (r_mode == REQ_FREE) ? (q_word & ~mask) : (q_word | mask);

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = i_in_data.req_type;
                    n_count   = i_in_data.page_count;
                    n_as_used = i_in_data.count_as_used;
                    n_first   = i_in_data.first_page;
                    n_last    = 12'(13'(i_in_data.first_page) + i_in_data.page_count - 13'd1);
                    n_status  = STAT_OK;
                    n_start   = '0;
                    n_run     = '0;
                    if (!type_ok || i_in_data.page_count == '0) begin
                        n_status = STAT_BAD;
                        n_state  = ST_OUT;
                    end else if (i_in_data.req_type == REQ_ALLOC) begin
                        if (i_in_data.page_count > 13'(PAGES)) begin
                            n_status = STAT_BAD;
                            n_state  = ST_OUT;
                        end else begin
                            rd_addr = '0;
                            n_word  = '0;
                            n_state = ST_SCAN;
                        end
                    end else if (idx_end > 14'(PAGES)) begin
                        n_status = STAT_BAD;
                        n_state  = ST_OUT;
                    end else begin
                        rd_addr = i_in_data.first_page[11:BIT_W];
                        n_word  = i_in_data.first_page[11:BIT_W];
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan.found) begin
                    if (scan.start == '0) begin
                        // The lowest free run starts at page zero: this fails.
                        n_status = STAT_NORUN;
                        n_state  = ST_OUT;
                    end else begin
                        n_start = scan.start;
                        n_first = scan.start;
                        n_last  = last_calc[11:0];
                        rd_addr = scan.start[11:BIT_W];
                        n_word  = scan.start[11:BIT_W];
                        n_state = ST_WRITE;
                    end
                end else if (r_word == WADDR_W'(WORDS - 1)) begin
                    n_status = STAT_NORUN;
                    n_state  = ST_OUT;
                end else begin
                    n_run   = scan.run;
                    rd_addr = r_word + WADDR_W'(1);
                    n_word  = r_word + WADDR_W'(1);
                end
            end
            ST_WRITE: begin
                wr_en = 1'b1;
                if (r_word == r_last[11:BIT_W]) begin
                    if (r_mode == REQ_FREE) begin
                        n_used = (r_count > r_used) ? '0 : r_used - r_count;
                    end else if (r_mode == REQ_ALLOC || r_as_used) begin
                        n_used = add_sum[13] ? COUNT_MAX : add_sum[12:0];
                    end
                    n_state = ST_OUT;
                end else begin
                    rd_addr = r_word + WADDR_W'(1);
                    n_word  = r_word + WADDR_W'(1);
                end
            end
            ST_OUT: begin
                // Wait until the output register is free to take the word.
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status     = r_status;
                    n_out.start_page = (r_status == STAT_OK) ? r_start : '0;
                    n_out.used_pages = r_used;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
